@@ hw/rtl/fba_pkg.sv @@
// Shared constants, types and helpers of the frame bitmap allocator.
`default_nettype none
package fba_pkg;

    localparam int BITMAP_WORDS = 1024;
    localparam int WORD_W       = 32;
    localparam int FRAME_W      = 15;
    localparam int BIT_W        = 5;
    localparam int FIELD_WORDS  = (1 << FRAME_W) / WORD_W;
    localparam int SCAN_WORDS   = (BITMAP_WORDS < FIELD_WORDS) ? BITMAP_WORDS : FIELD_WORDS;
    localparam int AW           = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int CW           = $clog2(BITMAP_WORDS + 1);

    localparam logic [31:0]       TOTAL_FRAMES = 32'(BITMAP_WORDS * WORD_W);
    localparam logic [WORD_W-1:0] FULL_WORD    = '1;
    localparam logic [CW-1:0]     LAST_CLEAR   = CW'(BITMAP_WORDS - 1);
    localparam logic [CW-1:0]     SCAN_END     = CW'(SCAN_WORDS);
    localparam logic [CW-1:0]     LAST_SCAN    = CW'(SCAN_WORDS - 1);
    localparam logic [BIT_W-1:0]  LAST_BIT     = BIT_W'(WORD_W - 1);

    typedef logic [AW-1:0]      t_addr;
    typedef logic [FRAME_W-1:0] t_frame;

    typedef enum logic [1:0] {
        OP_ALLOC_FIRST = 2'd0,
        OP_ALLOC_AT    = 2'd1,
        OP_FREE        = 2'd2,
        OP_TEST        = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_NO_CHANGE = 2'd1,
        STAT_NO_FREE   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_READ,
        S_MODIFY,
        S_SCAN,
        S_BITS
    } t_state;

    typedef struct packed {
        t_op    operation;
        t_frame frame_number;
        logic   supervisor;
        logic   writable;
        logic   entry_present;
        logic   entry_rw;
        logic   entry_user;
        t_frame entry_frame;
    } t_req;

    typedef struct packed {
        logic    out_present;
        logic    out_rw;
        logic    out_user;
        t_frame  out_frame;
        logic    frame_in_use;
        t_status status;
    } t_res;

    function automatic logic frame_exists(input t_frame f);
        return 32'(f) < TOTAL_FRAMES;
    endfunction

    function automatic t_addr word_of(input t_frame f);
        return AW'(f >> BIT_W);
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/fba_if.sv @@
// Request and result channel interfaces of the frame bitmap allocator.
`default_nettype none
interface fba_req_if import fba_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fba_res_if import fba_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/frame_bitmap_allocator.sv @@
// Top level of the first-fit page frame bitmap allocator.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------------
//  i_req   | in  | valid/ready         | operation, frame numbers, current entry
//  o_res   | out | valid/ready         | updated entry, frame_in_use, status
//
// After reset a clearing pass writes zero to all BITMAP_WORDS words, one per
// cycle, and no request is taken until it ends.
// Allocate-at, free and test step through accept, decode, read and modify;
// only allocate-at and free write back. Requests with status no-change finish in decode.
// Allocate-first streams one bitmap word per cycle through the RAM read port,
// then walks the chosen word one bit per cycle.
// A held result stalls completion only; the next request is taken meanwhile.
`default_nettype none
module frame_bitmap_allocator import fba_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fba_req_if.sink    i_req,
    fba_res_if.source  o_res
);

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic              r_dv, n_dv;
    logic [CW-1:0]     r_da, n_da;
    logic [WORD_W-1:0] r_word, n_word;
    t_addr             r_wa, n_wa;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic              r_ov;
    t_res              r_res;

    logic              ram_we;
    t_addr             ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    logic              accept, slot_free, fin, trivial, word_hit, bit_free;
    t_frame            req_f;
    t_addr             req_wa;
    logic [WORD_W-1:0] req_mask, bit_mask;
    t_res              res;

    fba_ram #(.WIDTH(WORD_W), .DEPTH(BITMAP_WORDS)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign slot_free   = !r_ov || o_res.ready;
    assign o_res.valid = r_ov;
    assign o_res.data  = r_res;

    assign req_f    = (r_req.operation == OP_FREE) ? r_req.entry_frame : r_req.frame_number;
    assign req_wa   = word_of(req_f);
    assign req_mask = {{(WORD_W-1){1'b0}}, 1'b1} << req_f[BIT_W-1:0];
    assign bit_mask = {{(WORD_W-1){1'b0}}, 1'b1} << r_bit;
    assign bit_free = !r_word[r_bit];
    assign word_hit = r_dv && ((ram_rdata != FULL_WORD) || (r_da == LAST_SCAN));

    always_comb begin
        case (r_req.operation)
            OP_ALLOC_FIRST: trivial = r_req.entry_present;
            OP_FREE:        trivial = (r_req.entry_frame == '0) || !frame_exists(req_f);
            default:        trivial = !frame_exists(req_f);
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_ptr == LAST_CLEAR) n_state = S_IDLE;
            S_IDLE:   if (accept) n_state = S_DECODE;
            S_DECODE: begin
                if (trivial) begin
                    if (fin) n_state = S_IDLE;
                end else if (r_req.operation == OP_ALLOC_FIRST) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ:   n_state = S_MODIFY;
            S_MODIFY: if (fin) n_state = S_IDLE;
            S_SCAN:   if (word_hit) n_state = S_BITS;
            S_BITS:   if (fin) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_req     = r_req;
        n_ptr     = r_ptr;
        n_dv      = r_dv;
        n_da      = r_da;
        n_word    = r_word;
        n_wa      = r_wa;
        n_bit     = r_bit;
        ram_we    = 1'b0;
        ram_waddr = req_wa;
        ram_wdata = ram_rdata;
        ram_raddr = req_wa;
        fin       = 1'b0;
        res.out_present  = r_req.entry_present;
        res.out_rw       = r_req.entry_rw;
        res.out_user     = r_req.entry_user;
        res.out_frame    = r_req.entry_frame;
        res.frame_in_use = 1'b0;
        res.status       = STAT_NO_CHANGE;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[AW-1:0];
                ram_wdata = '0;
                n_ptr     = (r_ptr == LAST_CLEAR) ? '0 : r_ptr + 1'b1;
            end
            S_IDLE: begin
                if (accept) n_req = i_req.data;
                n_ptr = '0;
                n_dv  = 1'b0;
            end
            S_DECODE: begin
                if (trivial) fin = slot_free;
            end
            S_MODIFY: begin
                fin        = slot_free;
                res.status = STAT_DONE;
                case (r_req.operation)
                    OP_ALLOC_AT: begin
                        ram_we          = fin;
                        ram_wdata       = ram_rdata | req_mask;
                        res.out_present = 1'b1;
                        res.out_rw      = r_req.writable;
                        res.out_user    = !r_req.supervisor;
                        res.out_frame   = r_req.frame_number;
                    end
                    OP_FREE: begin
                        ram_we          = fin;
                        ram_wdata       = ram_rdata & ~req_mask;
                        res.out_present = 1'b0;
                        res.out_frame   = '0;
                    end
                    default: begin
                        res.frame_in_use = |(ram_rdata & req_mask);
                    end
                endcase
            end
            S_SCAN: begin
                ram_raddr = r_ptr[AW-1:0];
                n_dv      = (r_ptr < SCAN_END);
                n_da      = r_ptr;
                if (r_ptr < SCAN_END) n_ptr = r_ptr + 1'b1;
                if (word_hit) begin
                    n_word = ram_rdata;
                    n_wa   = r_da[AW-1:0];
                    n_bit  = '0;
                end
            end
            S_BITS: begin
                if (bit_free) begin
                    fin             = slot_free;
                    ram_we          = fin;
                    ram_waddr       = r_wa;
                    ram_wdata       = r_word | bit_mask;
                    res.out_present = 1'b1;
                    res.out_rw      = r_req.writable;
                    res.out_user    = !r_req.supervisor;
                    res.out_frame   = FRAME_W'({r_wa, r_bit});
                    res.status      = STAT_DONE;
                end else if (r_bit == LAST_BIT) begin
                    fin        = slot_free;
                    res.status = STAT_NO_FREE;
                end else begin
                    n_bit = r_bit + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr   <= '0;
            r_dv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_dv    <= n_dv;
            if (fin) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_da   <= n_da;
        r_word <= n_word;
        r_wa   <= n_wa;
        r_bit  <= n_bit;
        if (fin) r_res <= res;
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |-> (!r_ov || o_res.ready))
        else $error("result completed while previous result still held");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DECODE || r_state == S_SCAN) |-> !ram_we)
        else $error("bitmap written outside clear or write-back");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr <= SCAN_END))
        else $error("scan pointer beyond scan range");

    a_no_free_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin && res.status == STAT_NO_FREE) |-> (r_word == FULL_WORD && r_wa == LAST_SCAN[AW-1:0]))
        else $error("no free frame reported before the last word was searched");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DECODE && !i_req.ready))
        else $error("request transfer not followed by decode");

endmodule
`default_nettype wire

@@ hw/rtl/fba_ram.sv @@
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW_L  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW_L-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW_L-1:0]  i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ bench/tb_frame_bitmap_allocator.sv @@
// Testbench for the first-fit page frame bitmap allocator with its own frame map model.
`timescale 1ns / 1ps
module tb_frame_bitmap_allocator;
    import fba_pkg::*;

    localparam int     CYCLE_LIMIT = 6_000_000;
    localparam int     HOLD_CYCLES = 300;
    localparam int     END_WAIT    = SCAN_WORDS + 40;
    localparam int     MAP_FRAMES  = BITMAP_WORDS * WORD_W;
    localparam t_frame MAXF        = '1;

    class alloc_scoreboard;
        logic [WORD_W-1:0] used_map [BITMAP_WORDS];
        t_res              due_results [$];
        int                errors;

        function new();
            foreach (used_map[w]) used_map[w] = '0;
            errors = 0;
        endfunction

        function bit on_map(input t_frame f);
            return int'(f) < MAP_FRAMES;
        endfunction

        function void mark_frame(input t_frame f, input bit used);
            used_map[f / WORD_W][f % WORD_W] = used;
        endfunction

        // Predicts the updated entry for an accepted request and queues it.
        function t_res note_request(input t_req r);
            t_res e;
            bit   found;
            int   hit;
            e.out_present  = r.entry_present;
            e.out_rw       = r.entry_rw;
            e.out_user     = r.entry_user;
            e.out_frame    = r.entry_frame;
            e.frame_in_use = 1'b0;
            e.status       = STAT_NO_CHANGE;
            found          = 1'b0;
            hit            = 0;
            case (r.operation)
                OP_ALLOC_FIRST: begin
                    if (!r.entry_present) begin
                        for (int w = 0; w < SCAN_WORDS && !found; w++) begin
                            if (used_map[w] != FULL_WORD) begin
                                for (int b = 0; b < WORD_W && !found; b++) begin
                                    if (!used_map[w][b]) begin
                                        found = 1'b1;
                                        hit   = w * WORD_W + b;
                                    end
                                end
                            end
                        end
                        if (!found) begin
                            e.status = STAT_NO_FREE;
                        end else begin
                            mark_frame(t_frame'(hit), 1'b1);
                            e.out_present = 1'b1;
                            e.out_rw      = r.writable;
                            e.out_user    = ~r.supervisor;
                            e.out_frame   = t_frame'(hit);
                            e.status      = STAT_DONE;
                        end
                    end
                end
                OP_ALLOC_AT: begin
                    if (on_map(r.frame_number)) begin
                        mark_frame(r.frame_number, 1'b1);
                        e.out_present = 1'b1;
                        e.out_rw      = r.writable;
                        e.out_user    = ~r.supervisor;
                        e.out_frame   = r.frame_number;
                        e.status      = STAT_DONE;
                    end
                end
                OP_FREE: begin
                    if (r.entry_frame != '0 && on_map(r.entry_frame)) begin
                        mark_frame(r.entry_frame, 1'b0);
                        e.out_present = 1'b0;
                        e.out_frame   = '0;
                        e.status      = STAT_DONE;
                    end
                end
                default: begin
                    if (on_map(r.frame_number)) begin
                        e.frame_in_use = used_map[r.frame_number / WORD_W][r.frame_number % WORD_W];
                        e.status       = STAT_DONE;
                    end
                end
            endcase
            due_results.push_back(e);
            return e;
        endfunction

        task report(input string what, input int got, input int want);
            errors++;
            if (errors <= 100) $display("mismatch: %s got %0h want %0h", what, got, want);
        endtask

        task check_result(input t_res r);
            t_res e;
            if (due_results.size() == 0) begin
                report("result with nothing due, frame", int'(r.out_frame), 0);
            end else begin
                e = due_results.pop_front();
                if (r.out_present !== e.out_present) begin
                    report("out_present", int'(r.out_present), int'(e.out_present));
                end
                if (r.out_rw !== e.out_rw) report("out_rw", int'(r.out_rw), int'(e.out_rw));
                if (r.out_user !== e.out_user) begin
                    report("out_user", int'(r.out_user), int'(e.out_user));
                end
                if (r.out_frame !== e.out_frame) begin
                    report("out_frame", int'(r.out_frame), int'(e.out_frame));
                end
                if (r.frame_in_use !== e.frame_in_use) begin
                    report("frame_in_use", int'(r.frame_in_use), int'(e.frame_in_use));
                end
                if (r.status !== e.status) report("status", int'(r.status), int'(e.status));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   quiet        = 1'b0;
    bit   hold_off_req = 1'b0;
    int   cycle_count  = 0;

    alloc_scoreboard sb;
    t_frame          owned_frames [$];

    fba_req_if req_if ();
    fba_res_if res_if ();

    frame_bitmap_allocator u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) sb.check_result(res_if.data);
    end

    // Result side: random back-pressure, quiet stretch, one long hold-off.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else if (quiet) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(99) >= 21);
            end
        end
    end

    function automatic t_req make_req(input t_op op, input t_frame fnum, input t_frame eframe,
                                      input bit kern, input bit wr, input bit pres,
                                      input bit rw, input bit usr);
        t_req r;
        r.operation     = op;
        r.frame_number  = fnum;
        r.supervisor    = kern;
        r.writable      = wr;
        r.entry_present = pres;
        r.entry_rw      = rw;
        r.entry_user    = usr;
        r.entry_frame   = eframe;
        return r;
    endfunction

    function automatic t_frame pick_frame();
        if ($urandom_range(99) < 75) return t_frame'($urandom_range(0, 511));
        return t_frame'($urandom_range(0, 32767));
    endfunction

    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic t_req random_req();
        t_req r;
        int   sel;
        int   idx;
        sel = $urandom_range(99);
        r = make_req(OP_TEST, pick_frame(), pick_frame(), coin(), coin(), coin(), coin(),
                     coin());
        if (sel < 30) begin
            r.operation     = OP_ALLOC_FIRST;
            r.entry_present = ($urandom_range(99) < 12);
        end else if (sel < 50) begin
            r.operation = OP_ALLOC_AT;
        end else if (sel < 75) begin
            r.operation = OP_FREE;
            if (owned_frames.size() != 0 && $urandom_range(99) < 75) begin
                idx           = $urandom_range(0, owned_frames.size() - 1);
                r.entry_frame = owned_frames[idx];
                owned_frames.delete(idx);
            end else if ($urandom_range(99) < 8) begin
                r.entry_frame = '0;
            end
        end else if (owned_frames.size() != 0 && $urandom_range(99) < 50) begin
            r.frame_number = owned_frames[$urandom_range(0, owned_frames.size() - 1)];
        end
        return r;
    endfunction

    task automatic send_request(input t_req r);
        t_res e;
        while (!quiet && $urandom_range(99) < 21) begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        e = sb.note_request(r);
        if (e.status == STAT_DONE &&
            (r.operation == OP_ALLOC_FIRST || r.operation == OP_ALLOC_AT)) begin
            owned_frames.push_back(e.out_frame);
        end
        @(negedge clk);
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        do @(negedge clk); while (sb.due_results.size() != 0);
    endtask

    initial begin
        sb           = new();
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rst_n        = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: field extremes, present entry, reuse, frame zero, word edges
        send_request(make_req(OP_TEST,        0,      0,      0, 0, 0, 0, 0));
        send_request(make_req(OP_ALLOC_FIRST, 0,      0,      0, 1, 0, 0, 0));
        send_request(make_req(OP_ALLOC_FIRST, 0,      77,     1, 1, 1, 1, 1));
        send_request(make_req(OP_ALLOC_FIRST, MAXF,   MAXF,   1, 0, 0, 1, 1));
        send_request(make_req(OP_ALLOC_AT,    MAXF,   0,      0, 1, 0, 0, 0));
        send_request(make_req(OP_TEST,        MAXF,   0,      0, 0, 0, 0, 0));
        send_request(make_req(OP_ALLOC_AT,    MAXF,   123,    1, 0, 1, 1, 0));
        send_request(make_req(OP_ALLOC_AT,    5,      9,      0, 0, 1, 0, 1));
        send_request(make_req(OP_FREE,        0,      0,      0, 0, 1, 1, 1));
        send_request(make_req(OP_FREE,        0,      MAXF,   0, 0, 1, 1, 0));
        send_request(make_req(OP_TEST,        MAXF,   MAXF,   1, 1, 1, 1, 1));
        send_request(make_req(OP_FREE,        0,      1000,   0, 0, 1, 0, 1));
        send_request(make_req(OP_ALLOC_FIRST, 0,      0,      1, 1, 0, 0, 0));
        send_request(make_req(OP_FREE,        0,      1,      1, 1, 1, 1, 1));
        send_request(make_req(OP_ALLOC_FIRST, 0,      0,      0, 0, 0, 1, 1));
        send_request(make_req(OP_ALLOC_AT,    'h2aaa, 'h5555, 1, 1, 0, 1, 0));
        send_request(make_req(OP_TEST,        'h5555, 'h2aaa, 1, 1, 1, 1, 1));
        send_request(make_req(OP_TEST,        'h2aaa, MAXF,   0, 0, 0, 0, 0));
        send_request(make_req(OP_ALLOC_AT,    31,     0,      0, 1, 0, 0, 0));
        send_request(make_req(OP_ALLOC_AT,    32,     0,      1, 0, 0, 0, 0));
        send_request(make_req(OP_TEST,        32,     0,      0, 0, 0, 0, 0));
        send_request(make_req(OP_TEST,        33,     0,      0, 0, 0, 0, 0));
        drain_results();

        for (int i = 0; i < 550; i++) begin
            if (i == 150) hold_off_req = 1'b1;
            quiet = (i >= 300 && i < 400);
            if (i == 450) drain_results();
            send_request(random_req());
        end
        drain_results();

        // closing: present entry, freed frames taken again, frame zero
        send_request(make_req(OP_ALLOC_FIRST, 0,    0,    0, 1, 0, 0, 0));
        send_request(make_req(OP_ALLOC_FIRST, MAXF, MAXF, 1, 0, 1, 1, 1));
        send_request(make_req(OP_FREE,        0,    MAXF, 0, 0, 1, 1, 1));
        send_request(make_req(OP_ALLOC_FIRST, 0,    0,    1, 1, 0, 0, 1));
        send_request(make_req(OP_FREE,        0,    'd4321, 1, 0, 1, 0, 0));
        send_request(make_req(OP_TEST,        'd4321, 0,  0, 0, 0, 0, 0));
        send_request(make_req(OP_ALLOC_FIRST, 0,    0,    0, 0, 0, 0, 0));
        send_request(make_req(OP_ALLOC_FIRST, 0,    'd17, 1, 1, 0, 1, 0));
        send_request(make_req(OP_FREE,        0,    0,    1, 1, 1, 1, 1));
        drain_results();
        repeat (END_WAIT) @(negedge clk);

        if (sb.due_results.size() != 0) sb.report("results still due", sb.due_results.size(), 0);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/fba_pkg.sv
hw/rtl/fba_if.sv
hw/rtl/fba_ram.sv
hw/rtl/frame_bitmap_allocator.sv
bench/tb_frame_bitmap_allocator.sv
